// ----- rtl/nrsh_pkg.sv -----
// Package for the nearest ray-sphere hit block: widths, table entry and
// write types, sequencer states and the saturation helper.
// Depends on nothing; every other file imports it.
package nrsh_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int CW  = 24;      // coordinate, Q15.8
    localparam int EW  = 16;      // diameter / probe radius, Q8.8
    localparam int DW  = CW + 1;  // coordinate difference
    localparam int SW  = EW + 2;  // diameter plus twice the radius
    localparam int MW  = 28;      // multiplier operand
    localparam int PW  = 2 * MW;  // product
    localparam int AW  = 52;      // sums of squares, dot products, dividends
    localparam int RW  = AW / 2;  // square root
    localparam int LW  = 26;      // segment length, divisor
    localparam int PJW = 27;      // projection
    localparam int HW  = 27;      // unsaturated hit and pre points

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic [EW-1:0]        diam;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic              occ;
        entry_t            entry;
    } tbl_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN2,
        ST_LSQRT,
        ST_SLOT,
        ST_LOAD,
        ST_DOT,
        ST_TT,
        ST_RR,
        ST_PROJ,
        ST_PP,
        ST_DSQRT,
        ST_HMUL,
        ST_QPRE,
        ST_FIN
    } state_t;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [HW-1:0] v);
        logic signed [HW-1:0] hi;
        logic signed [HW-1:0] lo;
        hi = HW'((1 <<< (CW - 1)) - 1);
        lo = -HW'(1 <<< (CW - 1));
        if (v > hi)
            return CW'(hi);
        else if (v < lo)
            return CW'(lo);
        else
            return CW'(v);
    endfunction

endpackage

// ----- rtl/nrsh_table.sv -----
// Sphere table: one synchronous memory of slot entries with registered read
// data, and the occupied marks in flip-flops cleared by reset.
// Depends on nrsh_pkg.
module nrsh_table
    import nrsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output entry_t            rd_data,
    output logic [SLOTS-1:0]  occ
);

    entry_t           mem_reg [SLOTS];
    entry_t           rd_data_reg;
    logic [SLOTS-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (wr.en)
        begin
            occ_reg[wr.addr] <= wr.occ;
        end
    end

    assign rd_data = rd_data_reg;
    assign occ     = occ_reg;

endmodule

// ----- rtl/nrsh_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on nrsh_pkg.
module nrsh_div
    import nrsh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] num,
    input  logic [LW-1:0] den,
    output logic [AW-1:0] quo,
    output logic          done
);

    localparam int CNT_W = $clog2(AW + 1);

    logic [AW-1:0]    quo_reg, quo_next;
    logic [LW-1:0]    rem_reg, rem_next;
    logic [LW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [LW:0]      trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[AW-1]};
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(AW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = LW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[AW-2:0], 1'b1};
            end
            else
            begin
                rem_next = LW'(trial);
                quo_next = {quo_reg[AW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- rtl/nrsh_sqrt.sv -----
// Integer square root, digit by digit, one result bit per cycle.
// Depends on nrsh_pkg.
module nrsh_sqrt
    import nrsh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] num,
    output logic [RW-1:0] root,
    output logic          done
);

    localparam int CNT_W = $clog2(RW + 1);

    logic [AW-1:0]    n_reg, n_next;
    logic [AW-1:0]    r_reg, r_next;
    logic [AW-1:0]    b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [AW-1:0]    trial;

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = r_reg + b_reg;
        if (start)
        begin
            n_next   = num;
            r_next   = '0;
            b_next   = AW'(1) << (AW - 2);
            cnt_next = CNT_W'(RW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next = n_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign root = RW'(r_reg);
    assign done = done_reg;

endmodule

// ----- rtl/nearest_ray_sphere_hit.sv -----
// Nearest ray-sphere hit. A write item is done in the idle state, which the
// block does not leave. A query first finds the segment length on the root
// unit, then steps through the slots: a skipped slot only advances, a tested
// slot uses the divider and the root unit, and a hit then works out the hit
// and pre points on the divider. One item is worked at a time. Reset clears
// all occupied marks at once; the centers and diameters are not cleared.
module nearest_ray_sphere_hit
    import nrsh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [3:0]           slot,
    input  logic                 present,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] az,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by,
    input  logic signed [CW-1:0] bz,
    input  logic [EW-1:0]        extent,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [3:0]           hit_slot,
    output logic signed [CW-1:0] hit_x,
    output logic signed [CW-1:0] hit_y,
    output logic signed [CW-1:0] hit_z,
    output logic signed [CW-1:0] pre_x,
    output logic signed [CW-1:0] pre_y,
    output logic signed [CW-1:0] pre_z
);

    // The sequencer walks one slot at a time: read the slot entry from the
    // table, form T = center - A, accumulate dot(T,D) and |T|^2 on the shared
    // multiplier, divide by the length, then take the root of the
    // discriminant. The nearest distance so far is kept with its slot.

    state_t state_reg, state_next;

    logic signed [CW-1:0]  a_reg [3];
    logic signed [CW-1:0]  a_next [3];
    logic signed [DW-1:0]  d_reg [3];
    logic signed [DW-1:0]  d_next [3];
    logic signed [DW-1:0]  t_reg [3];
    logic signed [DW-1:0]  t_next [3];
    logic signed [HW-1:0]  hp_reg [3];
    logic signed [HW-1:0]  hp_next [3];
    logic signed [CW-1:0]  rh_reg [3];
    logic signed [CW-1:0]  rh_next [3];
    logic signed [CW-1:0]  rp_reg [3];
    logic signed [CW-1:0]  rp_next [3];
    logic signed [CW-1:0]  oh_reg [3];
    logic signed [CW-1:0]  oh_next [3];
    logic signed [CW-1:0]  op_reg [3];
    logic signed [CW-1:0]  op_next [3];

    logic [EW-1:0]         ext_reg, ext_next;
    logic [3:0]            excl_reg, excl_next;
    logic                  excl_en_reg, excl_en_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [SW-1:0]         s_reg, s_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic signed [AW-1:0]  dot_reg, dot_next;
    logic signed [AW-1:0]  tt_reg, tt_next;
    logic signed [AW-1:0]  rr_reg, rr_next;
    logic signed [PJW-1:0] proj_reg, proj_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [MW-1:0]  best_v_reg, best_v_next;
    logic [SLOT_W-1:0]     best_reg, best_next;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [1:0]            step_reg, step_next;
    logic [1:0]            comp_reg, comp_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg, hit_next;
    logic [3:0]            hit_slot_reg, hit_slot_next;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic [1:0]            kidx;
    logic signed [AW-1:0]  mac_sum;
    logic signed [AW-1:0]  disc;
    logic signed [MW-1:0]  v;
    logic signed [HW-1:0]  q_s;
    logic                  advance;
    logic                  skip;

    tbl_wr_t               tbl_wr;
    logic                  rd_en;
    entry_t                rd_data;
    logic [SLOTS-1:0]      occ;

    logic                  div_start;
    logic [AW-1:0]         div_num;
    logic [AW-1:0]         div_quo;
    logic                  div_done;
    logic                  sqrt_start;
    logic [RW-1:0]         sqrt_root;
    logic                  sqrt_done;

    nrsh_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .occ     (occ)
    );

    nrsh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    nrsh_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .num   (acc_reg),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    // The shared multiplier: operands chosen by state, product registered.
    always_comb
    begin
        kidx  = (step_reg == 2'd3) ? 2'd2 : step_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LEN2:
            begin
                mul_a = MW'(d_reg[kidx]);
                mul_b = MW'(d_reg[kidx]);
            end
            ST_DOT:
            begin
                mul_a = MW'(t_reg[kidx]);
                mul_b = MW'(d_reg[kidx]);
            end
            ST_TT:
            begin
                mul_a = MW'(t_reg[kidx]);
                mul_b = MW'(t_reg[kidx]);
            end
            ST_RR:
            begin
                mul_a = MW'(s_reg);
                mul_b = MW'(s_reg);
            end
            ST_PP:
            begin
                mul_a = MW'(proj_reg);
                mul_b = MW'(proj_reg);
            end
            ST_HMUL:
            begin
                mul_a = MW'(d_reg[comp_reg]);
                mul_b = best_v_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
        mac_sum   = ((step_reg == 2'd1) ? '0 : acc_reg) + AW'(prod_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        hp_next        = hp_reg;
        rh_next        = rh_reg;
        rp_next        = rp_reg;
        oh_next        = oh_reg;
        op_next        = op_reg;
        ext_next       = ext_reg;
        excl_next      = excl_reg;
        excl_en_next   = excl_en_reg;
        len_next       = len_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        dot_next       = dot_reg;
        tt_next        = tt_reg;
        rr_next        = rr_reg;
        proj_next      = proj_reg;
        best_v_next    = best_v_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        comp_next      = comp_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        in_ready       = 1'b0;
        tbl_wr         = '0;
        rd_en          = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        sqrt_start     = 1'b0;
        advance        = 1'b0;
        skip           = 1'b0;
        disc           = mac_sum;
        v              = '0;
        q_s            = neg_reg ? -HW'(div_quo) : HW'(div_quo);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        tbl_wr.en         = (int'(slot) < SLOTS);
                        tbl_wr.addr       = SLOT_W'(slot);
                        tbl_wr.occ        = present;
                        tbl_wr.entry.cx   = ax;
                        tbl_wr.entry.cy   = ay;
                        tbl_wr.entry.cz   = az;
                        tbl_wr.entry.diam = extent;
                    end
                    else
                    begin
                        a_next[0]    = ax;
                        a_next[1]    = ay;
                        a_next[2]    = az;
                        d_next[0]    = DW'(bx) - DW'(ax);
                        d_next[1]    = DW'(by) - DW'(ay);
                        d_next[2]    = DW'(bz) - DW'(az);
                        ext_next     = extent;
                        excl_next    = slot;
                        excl_en_next = present;
                        found_next   = 1'b0;
                        step_next    = '0;
                        state_next   = ST_LEN2;
                    end
                end
            end
            ST_LEN2:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg != 2'd0)
                begin
                    acc_next = mac_sum;
                end
                if (step_reg == 2'd3)
                begin
                    step_next  = '0;
                    // A zero-length segment misses every sphere.
                    state_next = (mac_sum == '0) ? ST_FIN : ST_LSQRT;
                end
            end
            ST_LSQRT:
            begin
                if (step_reg == 2'd0)
                begin
                    sqrt_start = 1'b1;
                    step_next  = 2'd1;
                end
                else if (sqrt_done)
                begin
                    len_next   = LW'(sqrt_root);
                    idx_next   = '0;
                    step_next  = '0;
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                skip = !occ[idx_reg] || (excl_en_reg && (int'(idx_reg) == int'(excl_reg)));
                if (skip)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                t_next[0]  = DW'(rd_data.cx) - DW'(a_reg[0]);
                t_next[1]  = DW'(rd_data.cy) - DW'(a_reg[1]);
                t_next[2]  = DW'(rd_data.cz) - DW'(a_reg[2]);
                s_next     = SW'(rd_data.diam) + {1'b0, ext_reg, 1'b0};
                step_next  = '0;
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg != 2'd0)
                begin
                    acc_next = mac_sum;
                end
                if (step_reg == 2'd3)
                begin
                    dot_next   = mac_sum;
                    step_next  = '0;
                    state_next = ST_TT;
                end
            end
            ST_TT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg != 2'd0)
                begin
                    acc_next = mac_sum;
                end
                if (step_reg == 2'd3)
                begin
                    tt_next    = mac_sum;
                    step_next  = '0;
                    state_next = ST_RR;
                end
            end
            ST_RR:
            begin
                if (step_reg == 2'd0)
                begin
                    step_next = 2'd1;
                end
                else
                begin
                    rr_next    = AW'(prod_reg >>> 2);
                    step_next  = '0;
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ:
            begin
                if (step_reg == 2'd0)
                begin
                    div_start = 1'b1;
                    div_num   = dot_reg[AW-1] ? AW'(-dot_reg) : AW'(dot_reg);
                    neg_next  = dot_reg[AW-1];
                    step_next = 2'd1;
                end
                else if (div_done)
                begin
                    proj_next  = neg_reg ? -PJW'(div_quo) : PJW'(div_quo);
                    step_next  = '0;
                    state_next = ST_PP;
                end
            end
            ST_PP:
            begin
                if (step_reg == 2'd0)
                begin
                    step_next = 2'd1;
                end
                else
                begin
                    disc      = AW'(prod_reg) - tt_reg + rr_reg;
                    acc_next  = disc;
                    step_next = '0;
                    if (disc[AW-1])
                    begin
                        advance = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DSQRT;
                    end
                end
            end
            ST_DSQRT:
            begin
                if (step_reg == 2'd0)
                begin
                    sqrt_start = 1'b1;
                    step_next  = 2'd1;
                end
                else if (sqrt_done)
                begin
                    v         = MW'(proj_reg) - signed'(MW'(sqrt_root));
                    step_next = '0;
                    advance   = 1'b1;
                    if (!v[MW-1] && (v <= signed'(MW'(len_reg)))
                        && (!found_reg || (v < best_v_reg)))
                    begin
                        found_next  = 1'b1;
                        best_next   = idx_reg;
                        best_v_next = v;
                    end
                end
            end
            ST_HMUL:
            begin
                if (step_reg == 2'd0)
                begin
                    step_next = 2'd1;
                end
                else if (step_reg == 2'd1)
                begin
                    div_start = 1'b1;
                    div_num   = prod_reg[PW-1] ? AW'(-prod_reg) : AW'(prod_reg);
                    neg_next  = prod_reg[PW-1];
                    step_next = 2'd2;
                end
                else if (div_done)
                begin
                    hp_next[comp_reg] = HW'(a_reg[comp_reg]) + q_s;
                    step_next         = '0;
                    state_next        = ST_QPRE;
                end
            end
            ST_QPRE:
            begin
                if (step_reg == 2'd0)
                begin
                    div_start = 1'b1;
                    div_num   = d_reg[comp_reg][DW-1]
                                ? (AW'(-d_reg[comp_reg]) << 8)
                                : (AW'(d_reg[comp_reg]) << 8);
                    neg_next  = d_reg[comp_reg][DW-1];
                    step_next = 2'd1;
                end
                else if (div_done)
                begin
                    rh_next[comp_reg] = sat_cw(hp_reg[comp_reg]);
                    rp_next[comp_reg] = sat_cw(hp_reg[comp_reg] - q_s);
                    step_next         = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = ST_HMUL;
                    end
                end
            end
            ST_FIN:
            begin
                // Waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = found_reg;
                    hit_slot_next  = found_reg ? 4'(best_reg) : 4'd0;
                    for (int k = 0; k < 3; k++)
                    begin
                        oh_next[k] = found_reg ? rh_reg[k] : '0;
                        op_next[k] = found_reg ? rp_reg[k] : '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (idx_reg == SLOT_W'(SLOTS - 1))
            begin
                comp_next  = '0;
                state_next = found_next ? ST_HMUL : ST_FIN;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            step_reg      <= '0;
            comp_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            step_reg      <= step_next;
            comp_reg      <= comp_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        hp_reg       <= hp_next;
        rh_reg       <= rh_next;
        rp_reg       <= rp_next;
        oh_reg       <= oh_next;
        op_reg       <= op_next;
        ext_reg      <= ext_next;
        excl_reg     <= excl_next;
        excl_en_reg  <= excl_en_next;
        len_reg      <= len_next;
        s_reg        <= s_next;
        acc_reg      <= acc_next;
        dot_reg      <= dot_next;
        tt_reg       <= tt_next;
        rr_reg       <= rr_next;
        proj_reg     <= proj_next;
        prod_reg     <= prod_next;
        best_v_reg   <= best_v_next;
        best_reg     <= best_next;
        neg_reg      <= neg_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_slot  = hit_slot_reg;
    assign hit_x     = oh_reg[0];
    assign hit_y     = oh_reg[1];
    assign hit_z     = oh_reg[2];
    assign pre_x     = op_reg[0];
    assign pre_y     = op_reg[1];
    assign pre_z     = op_reg[2];

endmodule

// ----- rtl/nrsh_checker.sv -----
// Port-level checks for the nearest ray-sphere hit block, bound to the top.
// Depends on nrsh_pkg and nearest_ray_sphere_hit.
module nrsh_checker
    import nrsh_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 kind,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic [3:0]           hit_slot,
    input logic signed [CW-1:0] hit_x,
    input logic signed [CW-1:0] pre_x
);

    // A result waiting to be taken holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_x))
        else $error("result changed while stalled");

    // After a write item the block is ready again in the next cycle.
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_WRITE) |=> in_ready)
        else $error("write item did not finish in one cycle");

    // A query item keeps the block busy.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_QUERY) |=> !in_ready)
        else $error("query item did not occupy the sequencer");

    // A miss carries zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (hit_slot == 4'd0) && (hit_x == '0) && (pre_x == '0))
        else $error("miss result with nonzero fields");

endmodule

bind nearest_ray_sphere_hit nrsh_checker u_nrsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .hit_slot  (hit_slot),
    .hit_x     (hit_x),
    .pre_x     (pre_x)
);
